### rtl/particle_cone_isolation_macros.svh
// Assertion macros shared by the checker.
`ifndef PARTICLE_CONE_ISOLATION_MACROS_SVH
`define PARTICLE_CONE_ISOLATION_MACROS_SVH

// Asserts that prop holds at every clock edge outside reset.
`define PCI_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Asserts that the condition holds at every clock edge, reset included.
`define PCI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/pci_pkg.sv
`default_nettype none
package pci_pkg;

    localparam logic OP_LEPTON    = 1'b0;
    localparam logic OP_CANDIDATE = 1'b1;

    localparam logic [1:0] KIND_ELECTRON = 2'd1;
    localparam logic [1:0] KIND_MUON     = 2'd2;

    localparam logic [7:0] PDG_PHOTON  = 8'd22;
    localparam logic [7:0] PDG_NEUTRAL = 8'd130;
    localparam logic [7:0] PDG_PION    = 8'd211;
    localparam logic [7:0] PDG_MIN     = 8'd7;

    localparam logic [12:0] ETA_ENDCAP   = 13'd964;
    localparam logic [15:0] LOW_PT_LIMIT = 16'd20;
    localparam logic [23:0] OUT_MAX      = 24'hFFFFFF;

    localparam logic [1:0] CFG_RADIUS_MIN   = 2'd0;
    localparam logic [1:0] CFG_RADIUS_MAX   = 2'd1;
    localparam logic [1:0] CFG_RADIUS_SCALE = 2'd2;
    localparam logic [1:0] CFG_CHG_SUM_SEL  = 2'd3;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        opcode;
        logic [15:0] pt;
        logic [12:0] eta;
        logic [11:0] phi;
        logic [1:0]  lepton_kind;
        logic [7:0]  abs_pdg_id;
        logic [1:0]  charge;
        logic [1:0]  vertex_assoc;
        logic        last;
    } item_t;

    // Front-end classification of one item, carried through the queue.
    typedef struct packed {
        logic        opcode;
        logic        last;
        logic [15:0] pt;
        logic [12:0] eta;
        logic [11:0] phi;
        logic [1:0]  kind;
        logic        pdg_ok;
        logic        is_photon;
        logic        is_neutral;
        logic        is_pion;
        logic        is_neutral_charge;
        logic        is_primary;
    } work_t;

endpackage
`default_nettype wire

### rtl/pci_divider.sv
`default_nettype none
module pci_divider #(
    parameter int NUM_WIDTH = 32,
    parameter int DEN_WIDTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [NUM_WIDTH-1:0] numer,
    input  wire logic [DEN_WIDTH-1:0] denom,
    output logic                      done,
    output logic [NUM_WIDTH-1:0]      quot,
    output logic [DEN_WIDTH-1:0]      rem
);

    localparam int CW = $clog2(NUM_WIDTH + 1);

    logic [CW-1:0]        count_reg, count_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [NUM_WIDTH-1:0] q_reg, q_next;
    logic [DEN_WIDTH:0]   r_reg, r_next;
    logic [DEN_WIDTH-1:0] d_reg, d_next;
    logic [DEN_WIDTH:0]   trial;

    always_comb begin
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        q_next     = q_reg;
        r_next     = r_reg;
        d_next     = d_reg;
        trial      = {r_reg[DEN_WIDTH-1:0], q_reg[NUM_WIDTH-1]};
        if (start) begin
            busy_next  = 1'b1;
            count_next = CW'(NUM_WIDTH);
            q_next     = numer;
            r_next     = '0;
            d_next     = denom;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NUM_WIDTH-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[NUM_WIDTH-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg[DEN_WIDTH-1:0];

endmodule
`default_nettype wire

### rtl/pci_front.sv
`default_nettype none
module pci_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire pci_pkg::item_t in_item,
    output logic                q_valid,
    input  wire logic           q_ready,
    output pci_pkg::work_t      q_work
);

    localparam int AW = $clog2(pci_pkg::QUEUE_DEPTH);

    pci_pkg::work_t  mem_reg [pci_pkg::QUEUE_DEPTH];
    pci_pkg::work_t  cls;
    logic [AW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]     cnt_reg, cnt_next;
    logic            push, pop;

    always_comb begin
        cls.opcode            = in_item.opcode;
        cls.last              = in_item.last;
        cls.pt                = in_item.pt;
        cls.eta               = in_item.eta;
        cls.phi               = in_item.phi;
        cls.kind              = in_item.lepton_kind;
        cls.pdg_ok            = in_item.abs_pdg_id >= pci_pkg::PDG_MIN;
        cls.is_photon         = in_item.abs_pdg_id == pci_pkg::PDG_PHOTON;
        cls.is_neutral        = in_item.abs_pdg_id == pci_pkg::PDG_NEUTRAL;
        cls.is_pion           = in_item.abs_pdg_id == pci_pkg::PDG_PION;
        cls.is_neutral_charge = in_item.charge == 2'b00;
        cls.is_primary        = in_item.vertex_assoc > 2'd1;
    end

    assign in_ready = cnt_reg != (AW+1)'(pci_pkg::QUEUE_DEPTH);
    assign q_valid  = cnt_reg != '0;
    assign q_work   = mem_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_reg] <= cls;
        end
    end

endmodule
`default_nettype wire

### rtl/pci_back.sv
`default_nettype none
module pci_back #(
    parameter int SUM_WIDTH       = 32,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [11:0]    radius_min,
    input  wire logic [11:0]    radius_max,
    input  wire logic [23:0]    radius_scale,
    input  wire logic           chg_sum_sel,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire pci_pkg::work_t q_work,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [23:0]         out_ratio,
    output logic                out_low_pt
);

    localparam int NW = (SUM_WIDTH + 3 > 17 + RATIO_FRAC_BITS) ? SUM_WIDTH + 3
                                                             : 17 + RATIO_FRAC_BITS;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};
    localparam int IW = 24 - RATIO_FRAC_BITS;

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_RDIV  = 3'd1;
    localparam logic [2:0] ST_RSQ   = 3'd2;
    localparam logic [2:0] ST_IDIV  = 3'd3;
    localparam logic [2:0] ST_FDIV  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_CHECK = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [15:0] lpt_reg;
    logic [12:0] leta_reg;
    logic [11:0] lphi_reg;
    logic [1:0]  lkind_reg;
    logic [23:0] rsq_reg;
    logic [11:0] rad_reg;
    logic [SUM_WIDTH-1:0] sph_reg, snh_reg, sch_reg, spu_reg;
    logic        ovalid_reg;
    logic [23:0] oratio_reg;
    logic        olow_reg;
    logic        emit_reg;
    logic [NW-1:0] iq_reg;

    // Distance pipeline: stage one registers the deltas.
    logic        p1_valid_reg;
    pci_pkg::work_t p1_reg;
    logic [13:0] deta_reg;
    logic [11:0] dphi_reg;
    logic [13:0] deta_c;
    logic [11:0] dphi_c;
    logic signed [28:0] deta_w, dphi_w;
    logic [28:0] d2;
    logic [12:0] abs_eta;
    logic [11:0] dc_ch, dc_pu, dc_ph, dc_nh;
    logic [1:0]  thresh;
    logic        cone_in;

    logic              div_start, div_done;
    logic [NW-1:0]     div_num, div_q;
    logic [16:0]       div_den, div_rem;

    logic [NW-1:0] a_pos, a_sum, iso2;
    logic signed [NW:0] a_signed;

    pci_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(17)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .numer(div_num),
        .denom(div_den), .done(div_done), .quot(div_q), .rem(div_rem)
    );

    function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] s,
                                                     input logic [15:0] a);
        logic [SUM_WIDTH:0] t;
        t = {1'b0, s} + (SUM_WIDTH+1)'(a);
        return t[SUM_WIDTH] ? SUM_MAX : t[SUM_WIDTH-1:0];
    endfunction

    assign deta_c  = {q_work.eta[12], q_work.eta} - {leta_reg[12], leta_reg};
    assign dphi_c  = q_work.phi - lphi_reg;
    assign deta_w  = 29'($signed(deta_reg));
    assign dphi_w  = 29'($signed(dphi_reg));
    assign d2      = deta_w * deta_w + dphi_w * dphi_w;
    assign cone_in = d2 <= 29'(rsq_reg);
    assign abs_eta = leta_reg[12] ? 13'(-leta_reg) : leta_reg;

    always_comb begin
        dc_ch = '0; dc_pu = '0; dc_ph = '0; dc_nh = '0; thresh = 2'd2;
        if (lkind_reg == pci_pkg::KIND_ELECTRON) begin
            thresh = 2'd0;
            if (abs_eta > pci_pkg::ETA_ENDCAP) begin
                dc_ch = 12'd100; dc_pu = 12'd100; dc_ph = 12'd2704;
            end
        end else if (lkind_reg == pci_pkg::KIND_MUON) begin
            dc_ch = 12'd1; dc_pu = 12'd49; dc_ph = 12'd49; dc_nh = 12'd49;
        end
    end

    assign a_sum    = NW'({1'b0, sph_reg} + {1'b0, snh_reg}) << 1;
    assign a_signed = $signed({1'b0, a_sum}) - $signed((NW+1)'(spu_reg));
    assign a_pos    = a_signed[NW] || a_signed == '0 ? '0 : a_signed[NW-1:0];
    assign iso2     = chg_sum_sel ? NW'({sch_reg, 1'b0})
                                  : a_pos + NW'({sch_reg, 1'b0});

    // The queue is drained only while the pipeline can take the item: a lepton
    // waits until the stage ahead is empty.
    assign q_ready = state_reg == ST_RUN && !emit_reg && !(ovalid_reg && q_work.last)
                  && !(p1_valid_reg && p1_reg.last)
                  && !(p1_valid_reg && q_work.opcode == pci_pkg::OP_LEPTON);

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        case (state_reg)
            ST_RUN: begin
                if (q_valid && q_ready && q_work.opcode == pci_pkg::OP_LEPTON) begin
                    if (q_work.pt == '0) begin
                        state_next = ST_RSQ;
                    end else begin
                        div_start  = 1'b1;
                        div_num    = NW'(radius_scale);
                        div_den    = {1'b0, q_work.pt};
                        state_next = ST_RDIV;
                    end
                end else if (emit_reg) begin
                    if (lpt_reg < pci_pkg::LOW_PT_LIMIT) begin
                        state_next = ST_EMIT;
                    end else begin
                        div_start  = 1'b1;
                        div_num    = iso2;
                        div_den    = {lpt_reg, 1'b0};
                        state_next = ST_IDIV;
                    end
                end
            end
            ST_RDIV:  if (div_done) state_next = ST_RSQ;
            ST_RSQ:   state_next = ST_RUN;
            ST_IDIV: begin
                if (div_done) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (iq_reg >= NW'(1) << IW) begin
                    state_next = ST_EMIT;
                end else begin
                    div_start  = 1'b1;
                    div_num    = NW'(div_rem) << RATIO_FRAC_BITS;
                    div_den    = {lpt_reg, 1'b0};
                    state_next = ST_FDIV;
                end
            end
            ST_FDIV:  if (div_done) state_next = ST_EMIT;
            ST_EMIT:  if (!ovalid_reg) state_next = ST_RUN;
            default:  state_next = ST_RUN;
        endcase
    end

    logic [23:0] q_clamp;
    logic [11:0] r_sel;
    logic [11:0] r_big;
    assign q_clamp = lpt_reg == '0 ? pci_pkg::OUT_MAX
                   : (div_q[NW-1:24] != '0 ? pci_pkg::OUT_MAX : div_q[23:0]);
    assign r_sel = (q_clamp < 24'(radius_max)) ? q_clamp[11:0] : radius_max;
    assign r_big = (radius_max > radius_min) ? radius_max : radius_min;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            lpt_reg      <= '0;
            leta_reg     <= '0;
            lphi_reg     <= '0;
            lkind_reg    <= '0;
            rsq_reg      <= '0;
            rad_reg      <= '0;
            sph_reg      <= '0;
            snh_reg      <= '0;
            sch_reg      <= '0;
            spu_reg      <= '0;
            ovalid_reg   <= 1'b0;
            emit_reg     <= 1'b0;
            p1_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ovalid_reg && out_ready) ovalid_reg <= 1'b0;
            p1_valid_reg <= q_valid && q_ready && q_work.opcode == pci_pkg::OP_CANDIDATE;
            if (q_valid && q_ready && q_work.opcode == pci_pkg::OP_LEPTON) begin
                lpt_reg   <= q_work.pt;
                leta_reg  <= q_work.eta;
                lphi_reg  <= q_work.phi;
                lkind_reg <= q_work.kind;
                sph_reg   <= '0;
                snh_reg   <= '0;
                sch_reg   <= '0;
                spu_reg   <= '0;
                emit_reg  <= q_work.last;
            end
            if (p1_valid_reg && p1_reg.pdg_ok && cone_in) begin
                if (p1_reg.is_neutral_charge) begin
                    if (p1_reg.pt > 16'(thresh)) begin
                        if (p1_reg.is_photon && d2 >= 29'(dc_ph))
                            sph_reg <= sat_add(sph_reg, p1_reg.pt);
                        else if (p1_reg.is_neutral && d2 >= 29'(dc_nh))
                            snh_reg <= sat_add(snh_reg, p1_reg.pt);
                    end
                end else if (p1_reg.is_primary) begin
                    if (p1_reg.is_pion && d2 >= 29'(dc_ch))
                        sch_reg <= sat_add(sch_reg, p1_reg.pt);
                end else if (p1_reg.pt > 16'(thresh) && d2 >= 29'(dc_pu)) begin
                    spu_reg <= sat_add(spu_reg, p1_reg.pt);
                end
            end
            if (p1_valid_reg && p1_reg.last) emit_reg <= 1'b1;
            if (state_reg == ST_RDIV && div_done)
                rad_reg <= (r_sel < radius_min) ? radius_min : r_sel;
            if (state_reg == ST_RSQ) begin
                if (lpt_reg == '0)
                    rsq_reg <= {12'd0, r_big} * {12'd0, r_big};
                else
                    rsq_reg <= {12'd0, rad_reg} * {12'd0, rad_reg};
            end
            if (state_reg == ST_RUN && emit_reg && !(q_valid && q_ready
                    && q_work.opcode == pci_pkg::OP_LEPTON)) begin
                emit_reg <= 1'b0;
                if (lpt_reg < pci_pkg::LOW_PT_LIMIT) begin
                    oratio_reg <= pci_pkg::OUT_MAX;
                    olow_reg   <= 1'b1;
                end
            end
            if (state_reg == ST_IDIV && div_done) iq_reg <= div_q;
            if (state_reg == ST_CHECK && iq_reg >= NW'(1) << IW) begin
                oratio_reg <= pci_pkg::OUT_MAX;
                olow_reg   <= 1'b0;
            end
            if (state_reg == ST_FDIV && div_done) begin
                oratio_reg <= 24'(iq_reg << RATIO_FRAC_BITS) + 24'(div_q);
                olow_reg   <= 1'b0;
            end
            if (state_reg == ST_EMIT && !ovalid_reg) ovalid_reg <= 1'b1;
        end
        p1_reg   <= q_work;
        deta_reg <= deta_c;
        dphi_reg <= dphi_c;
    end

    assign out_valid  = ovalid_reg;
    assign out_ratio  = oratio_reg;
    assign out_low_pt = olow_reg;

endmodule
`default_nettype wire

### rtl/particle_cone_isolation.sv
// Cone isolation of a lepton over a stream of particle candidates. A lepton
// transfer (opcode 0 on s_tuser) opens a group and a transfer with tlast closes it
// and yields one result. Candidates are taken one per cycle, while the back end is
// running, through a four-entry queue and a two-stage distance pipeline. Each lepton
// holds the input while the cone radius is computed by a shared one-bit-per-cycle
// divider, and each result above the low-pt limit holds it for the integer and,
// when needed, the fraction division; candidates queue up behind those steps.
`default_nettype none
module particle_cone_isolation #(
    parameter int SUM_WIDTH       = 32,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pt, eta, phi, lepton_kind, abs_pdg_id, charge, vertex_assoc, 0 pad
    input  wire logic [55:0] s_tdata,
    // opcode
    input  wire logic        s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // iso_ratio
    output logic [23:0]      m_tdata,
    // low_pt
    output logic             m_tuser
);

    logic [11:0] rmin_reg, rmax_reg;
    logic [23:0] rscale_reg;
    logic        conly_reg;
    pci_pkg::item_t item;
    pci_pkg::work_t q_work;
    logic           q_valid, q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rmin_reg   <= 12'd33;
            rmax_reg   <= 12'd130;
            rscale_reg <= 24'd26076;
            conly_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pci_pkg::CFG_RADIUS_MIN:   rmin_reg   <= cfg_data[11:0];
                pci_pkg::CFG_RADIUS_MAX:   rmax_reg   <= cfg_data[11:0];
                pci_pkg::CFG_RADIUS_SCALE: rscale_reg <= cfg_data;
                pci_pkg::CFG_CHG_SUM_SEL:  conly_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        item.opcode       = s_tuser;
        item.pt           = s_tdata[15:0];
        item.eta          = s_tdata[28:16];
        item.phi          = s_tdata[40:29];
        item.lepton_kind  = s_tdata[42:41];
        item.abs_pdg_id   = s_tdata[50:43];
        item.charge       = s_tdata[52:51];
        item.vertex_assoc = s_tdata[54:53];
        item.last         = s_tlast;
    end

    pci_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_item(item), .q_valid(q_valid), .q_ready(q_ready), .q_work(q_work)
    );

    pci_back #(.SUM_WIDTH(SUM_WIDTH), .RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .radius_min(rmin_reg), .radius_max(rmax_reg),
        .radius_scale(rscale_reg), .chg_sum_sel(conly_reg), .q_valid(q_valid),
        .q_ready(q_ready), .q_work(q_work), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_ratio(m_tdata), .out_low_pt(m_tuser)
    );

endmodule
`default_nettype wire

### rtl/pci_checker.sv
`default_nettype none
`include "particle_cone_isolation_macros.svh"
module pci_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser
);
    `PCI_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    `PCI_ASSERT(a_low, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata == 24'hFFFFFF, "low pt ratio")
    `PCI_ASSERT(a_gap, aclk, aresetn, m_tvalid && m_tready |=> !m_tvalid, "back to back result")
    `PCI_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid && !s_tready || !m_tvalid, "reset")
endmodule

bind particle_cone_isolation pci_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
